// ===== design/polynomial_multiplier_assert.svh =====
// assertion macros for the polynomial multiplier
// used by the top level only, no other dependencies
`ifndef POLYNOMIAL_MULTIPLIER_ASSERT_SVH
`define POLYNOMIAL_MULTIPLIER_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define PM_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("polynomial_multiplier: same-cycle check failed");
// next-cycle implication
`define PM_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("polynomial_multiplier: next-cycle check failed");
`else
`define PM_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons)
`define PM_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons)
`endif

`endif

// ===== design/polymul_pkg.sv =====
// shared types and constants of the polynomial multiplier
// no dependencies
package polymul_pkg;

  localparam int COEF_W   = 16;
  localparam int EXP_W    = 5;
  localparam int STORE_W  = 24;
  localparam int PROD_W   = 48;
  localparam int PCOEF_W  = 54;
  localparam int PEXP_W   = 6;

  localparam logic signed [STORE_W-1:0] STORE_MAX = 24'sh7FFFFF;
  localparam logic signed [STORE_W-1:0] STORE_MIN = 24'sh800000;

  // operation codes carried in the input tuser
  typedef enum logic [1:0] {
    OP_LOAD_A   = 2'd0,
    OP_LOAD_B   = 2'd1,
    OP_MULTIPLY = 2'd2
  } opcode_t;

  // control of one operand store
  typedef struct packed {
    logic acc_en;
    logic clear;
  } store_ctrl_t;

  // control of the shared multiply-accumulate unit
  typedef struct packed {
    logic mul_en;
    logic acc_clr;
  } mac_ctrl_t;

endpackage

// ===== design/polymul_store.sv =====
// operand store: one coefficient per exponent, accumulate with saturation
// depends on polymul_pkg
module polymul_store import polymul_pkg::*; #(
  parameter int DEPTH = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  store_ctrl_t               ctrl,
  input  logic [$clog2(DEPTH)-1:0]  idx,
  input  logic signed [COEF_W-1:0]  coef,
  output logic signed [STORE_W-1:0] rd_data,
  output logic                      loaded
);

  logic signed [STORE_W-1:0] mem [DEPTH];
  logic signed [STORE_W:0]   sum;
  logic signed [STORE_W-1:0] sat;

  // single address serves both the read-modify-write and the operand read
  assign rd_data = mem[idx];

  // widened add then clamp to the 24-bit range
  always_comb begin
    sum = {rd_data[STORE_W-1], rd_data}
        + {{(STORE_W + 1 - COEF_W){coef[COEF_W-1]}}, coef};
    if (sum > $signed({STORE_MAX[STORE_W-1], STORE_MAX})) begin
      sat = STORE_MAX;
    end else if (sum < $signed({STORE_MIN[STORE_W-1], STORE_MIN})) begin
      sat = STORE_MIN;
    end else begin
      sat = sum[STORE_W-1:0];
    end
  end

  // entries and loaded flag
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      for (int n = 0; n < DEPTH; n++) begin
        mem[n] <= '0;
      end
      loaded <= 1'b0;
    end else if (ctrl.acc_en) begin
      mem[idx] <= sat;
      loaded   <= 1'b1;
    end
  end

endmodule

// ===== design/polymul_mac.sv =====
// shared multiply-accumulate unit: one 24x24 multiply per cycle, registered
// depends on polymul_pkg
module polymul_mac import polymul_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  mac_ctrl_t                 ctrl,
  input  logic signed [STORE_W-1:0] a,
  input  logic signed [STORE_W-1:0] b,
  output logic signed [PCOEF_W-1:0] acc
);

  logic signed [PROD_W-1:0] prod;
  logic                     prod_vld;

  // product register, then accumulate in the following cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
      acc      <= '0;
    end else begin
      prod_vld <= ctrl.mul_en;
      if (ctrl.mul_en) begin
        prod <= a * b;
      end
      if (ctrl.acc_clr) begin
        acc <= '0;
      end else if (prod_vld) begin
        acc <= acc + {{(PCOEF_W - PROD_W){prod[PROD_W-1]}}, prod};
      end
    end
  end

endmodule

// ===== design/polynomial_multiplier.sv =====
// polynomial multiplier top level: sequencer, two operand stores, one shared MAC
// a multiply is paced by the single shared 24x24 multiplier, which forms every partial
// product in turn, and can be stalled by the output; results leave in descending exponent
// order, one transaction at a time, the last held back until the next is known
// synchronous reset clears both stores, loaded flags, sequencer and output valid
`include "polynomial_multiplier_assert.svh"

module polynomial_multiplier import polymul_pkg::*; #(
  parameter int MAX_TERMS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,  // [15:0] term_coefficient, [20:16] term_exponent
  input  logic [1:0]  s_tuser,  // [1:0] opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,  // [53:0] product_coefficient, [59:54] product_exponent
  output logic        m_tlast,  // last_term
  output logic        m_tuser   // result_empty
);

  localparam int IW = $clog2(MAX_TERMS);
  localparam int KW = $clog2(2 * MAX_TERMS - 1);
  localparam logic [KW-1:0] K_TOP  = KW'(2 * MAX_TERMS - 2);
  localparam logic [KW-1:0] M_LAST = KW'(MAX_TERMS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC,
    S_SUM,
    S_EMIT,
    S_DONE
  } state_t;

  state_t state;
  logic [KW-1:0] k;
  logic [IW-1:0] i;

  logic               pend_vld;
  logic [PCOEF_W-1:0] pend_coef;
  logic [KW-1:0]      pend_exp;

  logic [PCOEF_W-1:0] out_coef;
  logic [PEXP_W-1:0]  out_exp;

  store_ctrl_t a_ctrl, b_ctrl;
  mac_ctrl_t   mac_ctrl;
  logic [IW-1:0] a_idx, b_idx;
  logic signed [STORE_W-1:0] a_rd, b_rd, a_eff, b_eff;
  logic a_loaded, b_loaded;
  logic signed [PCOEF_W-1:0] acc;

  opcode_t opcode;
  logic signed [COEF_W-1:0] in_coef;
  logic [EXP_W-1:0]  in_exp;
  logic              exp_ok;
  logic              out_free;
  logic              out_load;
  logic              nz;
  logic [KW-1:0]     j;
  logic [KW-1:0]     k_load;
  logic [IW-1:0]     i_load;
  logic [IW-1:0]     i_end;

  // input transaction fields
  assign opcode  = opcode_t'(s_tuser);
  assign in_coef = s_tdata[COEF_W-1:0];
  assign in_exp  = s_tdata[COEF_W +: EXP_W];
  assign exp_ok  = {1'b0, in_exp} < (EXP_W + 1)'(MAX_TERMS);

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign nz       = (acc != '0);

  // output register takes a new transaction
  assign out_load = out_free && ((state == S_EMIT && nz && pend_vld) || state == S_DONE);

  // exponent walk: j = k - i, and the valid range of i for a given k
  assign j      = k - KW'(i);
  assign k_load = (state == S_IDLE) ? K_TOP : k - KW'(1);
  assign i_load = (k_load > M_LAST) ? IW'(k_load - M_LAST) : '0;
  assign i_end  = (k > M_LAST) ? IW'(M_LAST) : IW'(k);

  // store addressing: load exponent while idle, walk indices otherwise
  assign a_idx = (state == S_IDLE) ? in_exp[IW-1:0] : i;
  assign b_idx = (state == S_IDLE) ? in_exp[IW-1:0] : j[IW-1:0];

  // an operand with no terms acts as the constant one when the other has terms
  always_comb begin
    if (a_loaded) begin
      a_eff = a_rd;
    end else if (b_loaded && i == '0) begin
      a_eff = STORE_W'(1);
    end else begin
      a_eff = '0;
    end
    if (b_loaded) begin
      b_eff = b_rd;
    end else if (a_loaded && j == '0) begin
      b_eff = STORE_W'(1);
    end else begin
      b_eff = '0;
    end
  end

  // store and MAC control
  always_comb begin
    a_ctrl   = '0;
    b_ctrl   = '0;
    mac_ctrl = '0;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          unique case (opcode)
            OP_LOAD_A:   a_ctrl.acc_en    = exp_ok;
            OP_LOAD_B:   b_ctrl.acc_en    = exp_ok;
            OP_MULTIPLY: mac_ctrl.acc_clr = 1'b1;
            default: ;
          endcase
        end
      end
      S_MAC:  mac_ctrl.mul_en = 1'b1;
      S_SUM:  ;
      S_EMIT: mac_ctrl.acc_clr = !(nz && pend_vld && !out_free) && (k != '0);
      S_DONE: begin
        a_ctrl.clear = out_free;
        b_ctrl.clear = out_free;
      end
      default: ;
    endcase
  end

  polymul_store #(.DEPTH(MAX_TERMS)) u_store_a (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (a_ctrl),
    .idx     (a_idx),
    .coef    (in_coef),
    .rd_data (a_rd),
    .loaded  (a_loaded)
  );

  polymul_store #(.DEPTH(MAX_TERMS)) u_store_b (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (b_ctrl),
    .idx     (b_idx),
    .coef    (in_coef),
    .rd_data (b_rd),
    .loaded  (b_loaded)
  );

  polymul_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctrl (mac_ctrl),
    .a    (a_eff),
    .b    (b_eff),
    .acc  (acc)
  );

  // sequencer, pending term and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      k        <= '0;
      i        <= '0;
      pend_vld <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid && opcode == OP_MULTIPLY) begin
            k     <= k_load;
            i     <= i_load;
            state <= S_MAC;
          end
        end
        S_MAC: begin
          if (i == i_end) begin
            state <= S_SUM;
          end else begin
            i <= i + IW'(1);
          end
        end
        S_SUM: state <= S_EMIT;
        S_EMIT: begin
          if (!(nz && pend_vld && !out_free)) begin
            if (nz) begin
              if (pend_vld) begin
                out_coef  <= pend_coef;
                out_exp   <= PEXP_W'(pend_exp);
                m_tlast   <= 1'b0;
                m_tuser   <= 1'b0;
              end
              pend_vld  <= 1'b1;
              pend_coef <= acc;
              pend_exp  <= k;
            end
            if (k == '0) begin
              state <= S_DONE;
            end else begin
              k     <= k_load;
              i     <= i_load;
              state <= S_MAC;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            m_tlast  <= 1'b1;
            if (pend_vld) begin
              out_coef <= pend_coef;
              out_exp  <= PEXP_W'(pend_exp);
              m_tuser  <= 1'b0;
            end else begin
              out_coef <= '0;
              out_exp  <= '0;
              m_tuser  <= 1'b1;
            end
            pend_vld <= 1'b0;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tdata = {(64 - PCOEF_W - PEXP_W)'(0), out_exp, out_coef};

  // the empty-product transaction is always final and carries a zero term
  `PM_ASSERT_IMPL(a_empty_final, clk, rst, m_tvalid && m_tuser, m_tlast && m_tdata[53:0] == 54'd0)
  // an ordinary transaction never carries a zero coefficient
  `PM_ASSERT_IMPL(a_term_nonzero, clk, rst, m_tvalid && !m_tuser, m_tdata[53:0] != 54'd0)
  // the multiplier index stays inside the store during the walk
  `PM_ASSERT_IMPL(a_walk_bounds, clk, rst, state == S_MAC, j <= M_LAST)
  // a finished multiply leaves both operands empty and the block idle
  `PM_ASSERT_NEXT(a_clear_after, clk, rst, state == S_DONE && out_free, !a_loaded && !b_loaded && s_tready)

endmodule
